// File: sv/htms_pkg.sv
`timescale 1ns / 1ps
// htms_pkg: constants, types and helper functions of the hybrid tag set.
// No dependencies; every other file of the block imports it.
package htms_pkg;

    localparam int FAST_TAG_BITS  = 256;
    localparam int OVERFLOW_DEPTH = 64;
    localparam int TAG_WIDTH      = 16;

    localparam int OP_WIDTH    = 2;
    localparam int USED_WIDTH  = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam int FAST_IDX_W = (FAST_TAG_BITS > 1) ? $clog2(FAST_TAG_BITS) : 1;
    localparam int COUNT_W    = $clog2(OVERFLOW_DEPTH + 1);
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCOUNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TAG_WIDTH-1:0]  tag_t;
    typedef logic [FAST_IDX_W-1:0] fast_idx_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [USED_WIDTH-1:0] used_t;

    localparam tag_t INVALID_TAG = {TAG_WIDTH{1'b1}};

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TEST   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_INVALID  = 3'b001,
        KIND_FAST     = 3'b010,
        KIND_OVERFLOW = 3'b100
    } kind_t;

    typedef struct packed {
        op_t   op;
        kind_t kind;
        tag_t  tag;
    } item_t;

    // Bit position of a small tag inside the flat bitmap.
    function automatic fast_idx_t fast_index(input tag_t t);
        logic [FAST_IDX_W+TAG_WIDTH-1:0] wide;
        wide = {{FAST_IDX_W{1'b0}}, t};
        return wide[FAST_IDX_W-1:0];
    endfunction

    // Overflow count as reported on the result channel (its low USED_WIDTH bits, which hold the whole count).
    function automatic used_t used_field(input count_t c);
        logic [COUNT_W+USED_WIDTH-1:0] wide;
        wide = {{USED_WIDTH{1'b0}}, c};
        return wide[USED_WIDTH-1:0];
    endfunction

endpackage

// File: sv/htms_req_if.sv
`timescale 1ns / 1ps
// htms_req_if: request channel (operation, tag) with valid/ready.
// Depends on htms_pkg.
interface htms_req_if;
    import htms_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_WIDTH-1:0] operation;
    tag_t                tag;

    modport source (output valid, output operation, output tag, input ready);
    modport sink   (input valid, input operation, input tag, output ready);
endinterface

// File: sv/htms_rsp_if.sv
`timescale 1ns / 1ps
// htms_rsp_if: result channel (found, refused, set_empty, overflow_used).
// Depends on htms_pkg.
interface htms_rsp_if;
    import htms_pkg::*;

    logic  valid;
    logic  ready;
    logic  found;
    logic  refused;
    logic  set_empty;
    used_t overflow_used;

    modport source (output valid, output found, output refused, output set_empty,
                    output overflow_used, input ready);
    modport sink   (input valid, input found, input refused, input set_empty,
                    input overflow_used, output ready);
endinterface

// File: sv/htms_front.sv
`timescale 1ns / 1ps
// htms_front: accepts request transactions and classifies each one.
// Depends on htms_pkg and htms_req_if.
module htms_front (
    htms_req_if.sink        req,
    output logic            push_valid,
    input  logic            push_ready,
    output htms_pkg::item_t push_item
);
    import htms_pkg::*;

    op_t   op;
    kind_t kind;

    always_comb
    begin
        case (req.operation)
            OP_ADD:    op = OP_ADD;
            OP_REMOVE: op = OP_REMOVE;
            default:   op = OP_TEST;   // code three acts as a test
        endcase

        if (req.tag == INVALID_TAG)
            kind = KIND_INVALID;
        else if (32'(req.tag) < 32'(FAST_TAG_BITS))
            kind = KIND_FAST;
        else
            kind = KIND_OVERFLOW;
    end

    assign push_valid     = req.valid;
    assign req.ready      = push_ready;
    assign push_item.op   = op;
    assign push_item.kind = kind;
    assign push_item.tag  = req.tag;

endmodule

// File: sv/htms_queue.sv
`timescale 1ns / 1ps
// htms_queue: short FIFO of classified items between front and back.
// Depends on htms_pkg.
module htms_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  htms_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output htms_pkg::item_t pop_item
);
    import htms_pkg::*;

    typedef logic [QPTR_W-1:0]   qptr_t;
    typedef logic [QCOUNT_W-1:0] qcount_t;

    item_t   mem_reg [QUEUE_DEPTH];
    qptr_t   wr_ptr_reg, wr_ptr_next;
    qptr_t   rd_ptr_reg, rd_ptr_next;
    qcount_t count_reg, count_next;
    logic    push, pop;

    function automatic qptr_t bump(input qptr_t p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != QCOUNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCOUNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");

    a_full_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == QCOUNT_W'(QUEUE_DEPTH) |-> !push)
        else $error("push into a full queue");

endmodule

// File: sv/htms_back.sv
`timescale 1ns / 1ps
// htms_back: executes items on the bitmap and the sorted overflow cells,
// and holds the result register. Depends on htms_pkg and htms_rsp_if.
module htms_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  htms_pkg::item_t pop_item,
    htms_rsp_if.source      rsp
);
    import htms_pkg::*;

    logic [FAST_TAG_BITS-1:0]  bitmap_reg, bitmap_next;
    tag_t                      entries_reg [OVERFLOW_DEPTH];
    tag_t                      ins_entry   [OVERFLOW_DEPTH];
    tag_t                      del_entry   [OVERFLOW_DEPTH];
    count_t                    count_reg, count_next;
    logic [OVERFLOW_DEPTH-1:0] lt_vec, eq_vec;

    logic  out_valid_reg;
    logic  found_reg, refused_reg, empty_reg;
    used_t used_reg;

    logic      fire;
    logic      found, refused, ins, del;
    logic      ovf_full;
    fast_idx_t fidx;

    assign fire      = pop_valid && (!out_valid_reg || rsp.ready);
    assign pop_ready = fire;
    assign fidx      = fast_index(pop_item.tag);
    assign ovf_full  = (count_reg == COUNT_W'(OVERFLOW_DEPTH));

    // Each cell compares against the tag; lt_vec is a thermometer over the
    // sorted live entries, so its first zero is the insert/erase position.
    for (genvar k = 0; k < OVERFLOW_DEPTH; k++)
    begin : g_cell
        logic live;
        assign live      = (COUNT_W'(k) < count_reg);
        assign lt_vec[k] = live && (entries_reg[k] < pop_item.tag);
        assign eq_vec[k] = live && (entries_reg[k] == pop_item.tag);

        if (k == 0)
        begin : g_ins_first
            assign ins_entry[k] = lt_vec[k] ? entries_reg[k] : pop_item.tag;
        end
        else
        begin : g_ins_rest
            assign ins_entry[k] = lt_vec[k]     ? entries_reg[k]   :
                                  lt_vec[k - 1] ? pop_item.tag     :
                                                  entries_reg[k - 1];
        end

        if (k == OVERFLOW_DEPTH - 1)
        begin : g_del_last
            assign del_entry[k] = entries_reg[k];
        end
        else
        begin : g_del_rest
            assign del_entry[k] = lt_vec[k] ? entries_reg[k] : entries_reg[k + 1];
        end
    end

    always_comb
    begin
        found       = 1'b0;
        refused     = 1'b0;
        ins         = 1'b0;
        del         = 1'b0;
        bitmap_next = bitmap_reg;
        case (pop_item.kind)
            KIND_INVALID:
            begin
                refused = (pop_item.op == OP_ADD);
            end
            KIND_FAST:
            begin
                found = bitmap_reg[fidx];
                if (pop_item.op == OP_ADD)
                    bitmap_next[fidx] = 1'b1;
                else if (pop_item.op == OP_REMOVE)
                    bitmap_next[fidx] = 1'b0;
            end
            KIND_OVERFLOW:
            begin
                found = |eq_vec;
                if (pop_item.op == OP_ADD && !found)
                begin
                    if (ovf_full)
                        refused = 1'b1;
                    else
                        ins = 1'b1;
                end
                else if (pop_item.op == OP_REMOVE && found)
                    del = 1'b1;
            end
            default:
            begin
                found = 1'b0;
            end
        endcase

        if (ins)
            count_next = count_reg + 1'b1;
        else if (del)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                bitmap_reg    <= bitmap_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            found_reg   <= found;
            refused_reg <= refused;
            empty_reg   <= (bitmap_next == '0) && (count_next == '0);
            used_reg    <= used_field(count_next);
            if (ins)
                entries_reg <= ins_entry;
            else if (del)
                entries_reg <= del_entry;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = found_reg;
    assign rsp.refused       = refused_reg;
    assign rsp.set_empty     = empty_reg;
    assign rsp.overflow_used = used_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(OVERFLOW_DEPTH))
        else $error("overflow count above depth");

    a_fast_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pop_item.kind == KIND_FAST |=> $stable(count_reg))
        else $error("small tag changed overflow count");

    a_refuse_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pop_item.op != OP_ADD |=> !refused_reg)
        else $error("refusal on a non-add item");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= COUNT_W'(2) |-> entries_reg[0] < entries_reg[1])
        else $error("overflow list out of order");

endmodule

// File: sv/hybrid_tag_membership_set_core.sv
`timescale 1ns / 1ps
// hybrid_tag_membership_set_core: top level of the hybrid tag set.
// Depends on htms_pkg, htms_req_if, htms_rsp_if, htms_front, htms_queue, htms_back.
//
//   Channel   Dir   Payload                                        Handshake
//   req       in    operation[1:0], tag[TAG_WIDTH-1:0]             valid/ready
//   rsp       out   found, refused, set_empty, overflow_used[6:0]  valid/ready
//
// Cycles: one transaction per cycle while rsp is ready, carried by the parallel
//   compare and shift of the overflow cells in the back end.
// Path: an accepted item waits in the queue; the back end then registers its result.
// Reset: bitmap and overflow count clear at once; no clearing pass, the
//   overflow entries are not reset and only live cells are ever compared.
// Stalls: a two-entry queue parts front and back; rsp backpressure stalls
//   the back end, and req.ready drops only once the queue is full.
module hybrid_tag_membership_set_core (
    input  logic       clk,
    input  logic       rst_n,
    htms_req_if.sink   req,
    htms_rsp_if.source rsp
);
    import htms_pkg::*;

    // front -> queue
    logic  push_valid, push_ready;
    item_t push_item;

    // queue -> back
    logic  pop_valid, pop_ready;
    item_t pop_item;

    // Front: classify tag as invalid, small (bitmap) or large (overflow list).
    htms_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    htms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: owns all set state and the result register.
    htms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .rsp       (rsp)
    );

endmodule

// File: sim/tb_hybrid_tag_membership_set_core.sv
`timescale 1ns / 1ps
// tb_hybrid_tag_membership_set_core: self-checking bench for the hybrid tag set core.
// Depends on htms_pkg, htms_req_if, htms_rsp_if and hybrid_tag_membership_set_core.
module tb_hybrid_tag_membership_set_core;
    import htms_pkg::*;

    // Operation code three is decoded as a membership test.
    localparam logic [OP_WIDTH-1:0] OP_TEST_ALIAS = 2'd3;

    // Receiver hold-off used to back the block up to a full input stall.
    localparam int PRESSURE_CYCLES = 200;
    // Cycles without any transaction on either channel before giving up.
    localparam int STALL_LIMIT     = 3000;
    // Cycles allowed after the last result before closing the run.
    localparam int SETTLE_CYCLES   = 8;

    // Expected outcome of one request.
    typedef struct {
        logic  found;
        logic  refused;
        logic  set_empty;
        used_t used;
    } set_result_t;

    // Tracks the tag set as the block should hold it and checks every result
    // against the oldest outstanding request.
    class tag_set_tracker;
        logic [FAST_TAG_BITS-1:0] small_bits;
        tag_t                     big_tags[$];    // sorted ascending, no duplicates
        set_result_t              expected_results[$];
        int mismatches;
        int requests;
        int results;
        int refusals;
        int hits;
        int peak_used;

        function new();
            small_bits  = '0;
            mismatches  = 0;
            requests    = 0;
            results     = 0;
            refusals    = 0;
            hits        = 0;
            peak_used   = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function bit holds_tag(tag_t t);
            foreach (big_tags[i])
                if (big_tags[i] == t)
                    return 1'b1;
            return 1'b0;
        endfunction

        function int overflow_size();
            return big_tags.size();
        endfunction

        function void snapshot(output tag_t small_list[$], output tag_t big_list[$]);
            small_list = {};
            for (int i = 0; i < FAST_TAG_BITS; i++)
                if (small_bits[i])
                    small_list.insert(small_list.size(), tag_t'(i));
            big_list = big_tags;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(logic [OP_WIDTH-1:0] op, tag_t t);
            set_result_t r;
            int pos;
            r.found   = 1'b0;
            r.refused = 1'b0;
            if (t == INVALID_TAG) begin
                if (op == OP_ADD)
                    r.refused = 1'b1;
            end
            else if (int'(t) < FAST_TAG_BITS) begin
                r.found = small_bits[t];
                if (op == OP_ADD)
                    small_bits[t] = 1'b1;
                else if (op == OP_REMOVE)
                    small_bits[t] = 1'b0;
            end
            else begin
                pos = 0;
                while (pos < big_tags.size() && big_tags[pos] < t)
                    pos++;
                r.found = (pos < big_tags.size()) && (big_tags[pos] == t);
                if (op == OP_ADD && !r.found) begin
                    if (big_tags.size() >= OVERFLOW_DEPTH)
                        r.refused = 1'b1;
                    else
                        big_tags.insert(pos, t);
                end
                else if (op == OP_REMOVE && r.found) begin
                    big_tags.delete(pos);
                end
            end
            r.set_empty = (small_bits == '0) && (big_tags.size() == 0);
            r.used      = used_t'(big_tags.size());
            if (big_tags.size() > peak_used)
                peak_used = big_tags.size();
            if (r.refused)
                refusals++;
            if (r.found)
                hits++;
            requests++;
            expected_results.insert(expected_results.size(), r);
        endfunction

        task check_result(logic found, logic refused, logic set_empty, used_t used);
            set_result_t r;
            results++;
            if (expected_results.size() == 0) begin
                report("result transaction with no outstanding request");
                return;
            end
            r = expected_results.pop_front();
            if (found !== r.found)
                report($sformatf("result %0d found=%b, want %b", results, found, r.found));
            if (refused !== r.refused)
                report($sformatf("result %0d refused=%b, want %b", results, refused,
                                 r.refused));
            if (set_empty !== r.set_empty)
                report($sformatf("result %0d set_empty=%b, want %b", results, set_empty,
                                 r.set_empty));
            if (used !== r.used)
                report($sformatf("result %0d overflow_used=%0d, want %0d", results, used,
                                 r.used));
        endtask

        task check_drained();
            if (expected_results.size() != 0)
                report($sformatf("%0d results never arrived", expected_results.size()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    htms_req_if req_ch ();
    htms_rsp_if rsp_ch ();

    hybrid_tag_membership_set_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tag_set_tracker tracker;

    // Idle percentages for each side; the stimulus retunes them per phase.
    int tx_idle_pct;
    int rx_idle_pct;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit pressure_req;
    bit pressure_done;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [OP_WIDTH-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_ADD;
        if (r < 75)
            return OP_REMOVE;
        if (r < 95)
            return OP_TEST;
        return OP_TEST_ALIAS;
    endfunction

    function automatic tag_t pick_large(int lo, int hi);
        return tag_t'($urandom_range(lo, hi));
    endfunction

    // One request transaction: optional idle gap, then hold valid until ready.
    // Everything changes on the falling edge; acceptance is judged at the
    // rising edge from the settled pre-edge values.
    task automatic send_item(input logic [OP_WIDTH-1:0] op, input tag_t t);
        int gap;
        gap = pick_gap(tx_idle_pct);
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.tag       <= t;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        tracker.note_request(op, t);
    endtask

    // Remove every tag currently held, in random order, with some tests mixed in.
    task automatic drain_set();
        tag_t small_list[$];
        tag_t big_list[$];
        tag_t all_tags[$];
        tag_t tmp;
        int j;
        tracker.snapshot(small_list, big_list);
        all_tags = {small_list, big_list};
        for (int i = all_tags.size() - 1; i > 0; i--)
        begin
            j           = $urandom_range(0, i);
            tmp         = all_tags[i];
            all_tags[i] = all_tags[j];
            all_tags[j] = tmp;
        end
        foreach (all_tags[i])
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(OP_TEST, all_tags[i]);
            send_item(OP_REMOVE, all_tags[i]);
        end
    endtask

    // Fill the overflow list to capacity, then probe behavior while it is full.
    task automatic fill_overflow(input int lo, input int hi);
        tag_t t;
        tag_t big_list[$];
        tag_t small_list[$];
        while (tracker.overflow_size() < OVERFLOW_DEPTH)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(OP_ADD, tag_t'($urandom_range(0, FAST_TAG_BITS - 1)));
            send_item(OP_ADD, pick_large(lo, hi));
        end
        tracker.snapshot(small_list, big_list);
        repeat (10)
        begin
            case ($urandom_range(0, 3))
                0: send_item(OP_ADD, big_list[$urandom_range(0, big_list.size() - 1)]);
                1:
                begin
                    // a new large tag must be turned away
                    do
                        t = pick_large(FAST_TAG_BITS, int'(INVALID_TAG) - 1);
                    while (tracker.holds_tag(t));
                    send_item(OP_ADD, t);
                end
                2: send_item(OP_TEST, big_list[$urandom_range(0, big_list.size() - 1)]);
                default: send_item(OP_ADD, tag_t'($urandom_range(0, FAST_TAG_BITS - 1)));
            endcase
        end
        // Always at least one refusal of a new tag at full occupancy.
        do
            t = pick_large(FAST_TAG_BITS, int'(INVALID_TAG) - 1);
        while (tracker.holds_tag(t));
        send_item(OP_ADD, t);
    endtask

    // Random operations on tags that overlap the set's contents. The narrow
    // large-tag window is just wider than the list, so it runs up to full.
    task automatic churn(input int count);
        tag_t t;
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                t = tag_t'($urandom_range(0, FAST_TAG_BITS - 1));
            else if (r < 85)
                t = pick_large(FAST_TAG_BITS, FAST_TAG_BITS + OVERFLOW_DEPTH + 4);
            else if (r < 95)
            begin
                case ($urandom_range(0, 4))
                    0: t = '0;
                    1: t = tag_t'(FAST_TAG_BITS - 1);
                    2: t = tag_t'(FAST_TAG_BITS);
                    3: t = INVALID_TAG - 1'b1;
                    default: t = INVALID_TAG;
                endcase
            end
            else
                t = tag_t'($urandom());
            send_item(pick_op(), t);
        end
    endtask

    // Receiver: decides ready on every falling edge; exactly one assignment
    // per edge. The long hold-off is counted here, independent of the sender.
    initial
    begin
        int gap_left;
        int hold_left;
        gap_left      = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        rsp_ch.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    pressure_done = 1'b1;
            end
            else if (pressure_req)
            begin
                pressure_req = 1'b0;
                hold_left    = PRESSURE_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                gap_left = pick_gap(rx_idle_pct);
            end
        end
    end

    // Result monitor.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                tracker.check_result(rsp_ch.found, rsp_ch.refused, rsp_ch.set_empty,
                                     rsp_ch.overflow_used);
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("[hybrid_tag_membership_set_core] ERROR");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        tracker          = new();
        tx_idle_pct      = 20;
        rx_idle_pct      = 20;
        pressure_req     = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_TEST;
        req_ch.tag       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: boundaries of the bitmap and the overflow range, the
        // invalid tag on every operation, duplicate add, absent remove,
        // code three as test, and a return to the empty set.
        send_item(OP_ADD, '0);
        send_item(OP_TEST, '0);
        send_item(OP_ADD, '0);
        send_item(OP_ADD, tag_t'(FAST_TAG_BITS - 1));
        send_item(OP_ADD, tag_t'(FAST_TAG_BITS));
        send_item(OP_ADD, INVALID_TAG - 1'b1);
        send_item(OP_ADD, INVALID_TAG - 1'b1);
        send_item(OP_TEST, INVALID_TAG - 1'b1);
        send_item(OP_ADD, INVALID_TAG);
        send_item(OP_TEST, INVALID_TAG);
        send_item(OP_REMOVE, INVALID_TAG);
        send_item(OP_TEST_ALIAS, tag_t'(FAST_TAG_BITS - 1));
        send_item(OP_TEST_ALIAS, INVALID_TAG);
        send_item(OP_REMOVE, tag_t'(300));
        send_item(OP_REMOVE, '0);
        send_item(OP_REMOVE, tag_t'(FAST_TAG_BITS - 1));
        send_item(OP_REMOVE, tag_t'(FAST_TAG_BITS));
        send_item(OP_REMOVE, INVALID_TAG - 1'b1);
        send_item(OP_TEST, '0);
        send_item(OP_ADD, tag_t'(64));
        send_item(OP_ADD, tag_t'(63));
        send_item(OP_REMOVE, tag_t'(64));
        send_item(OP_REMOVE, tag_t'(63));

        // Full-speed fill with the receiver held off: the internal queue
        // fills and req.ready must drop until the receiver comes back.
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        pressure_req = 1'b1;
        fill_overflow(FAST_TAG_BITS, int'(INVALID_TAG) - 1);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        drain_set();

        // Second fill over a narrow window, so neighbors sort tightly.
        tx_idle_pct = 10;
        rx_idle_pct = 50;
        fill_overflow(FAST_TAG_BITS, FAST_TAG_BITS + 2 * OVERFLOW_DEPTH);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_set();

        // Random churn in chunks with varying idle pressure on both sides.
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            case ($urandom_range(0, 3))
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 10;
                2: tx_idle_pct = 30;
                default: tx_idle_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0: rx_idle_pct = 0;
                1: rx_idle_pct = 10;
                2: rx_idle_pct = 30;
                default: rx_idle_pct = 60;
            endcase
            churn(100);
        end

        // Noise: any code, any tag.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        repeat (100)
            send_item(OP_WIDTH'($urandom_range(0, 3)), tag_t'($urandom()));

        drain_set();
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Wait for every outstanding result, then a settle period so a
        // stray extra result would still be caught.
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        tracker.check_drained();

        $display("covered %0d requests and %0d results: %0d hits, %0d refused adds",
                 tracker.requests, tracker.results, tracker.hits, tracker.refusals);
        $display("peak overflow occupancy %0d of %0d, long receiver hold-off %0s",
                 tracker.peak_used, OVERFLOW_DEPTH, pressure_done ? "done" : "missed");
        if (tracker.mismatches == 0)
            $display("[hybrid_tag_membership_set_core] OK");
        else
            $display("[hybrid_tag_membership_set_core] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/htms_pkg.sv
sv/htms_req_if.sv
sv/htms_rsp_if.sv
sv/htms_front.sv
sv/htms_queue.sv
sv/htms_back.sv
sv/hybrid_tag_membership_set_core.sv
sim/tb_hybrid_tag_membership_set_core.sv
